FILE: hdl/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    typedef struct packed {
        logic       byte_en;
        logic       word_done;
        logic [7:0] byte_val;
        logic       word_en;
        word_t      word_val;
        logic       step;
    } sched_ctl_t;

    typedef struct packed {
        logic       init;
        logic       step;
        logic [5:0] idx;
    } rnd_ctl_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [3:0] DIGEST_LEN  = 4'd8;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_hash_engine.sv
// Channel  Dir  tdata              tuser             tlast
// s_*      in   byte_value[7:0]    byte_present      message_end
// m_*      out  digest_word[31:0]  word_number[2:0]  last_word
//
// Bytes are taken one per cycle while a block fills.
// A full block stalls input for 64 rounds on the single round unit and the chain update.
// Message end: pad bytes one per cycle up to offset 56, a turn state, the two length words,
// then rounds and chain update per compressed block (one or two); digest bank loads once empty.
// Digest words drain one per cycle under m_tready; input may resume while they drain.
// rst_n is asynchronous: control, counters and chain hash return to their initial values.
`default_nettype none
module sha256_hash_engine (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] byte_value
    input  wire  [0:0]  s_tuser,   // [0] byte_present
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] bits_reg, bits_next;
    logic        pad_reg, pad_next;
    logic        pad_first_reg, pad_first_next;
    logic        final_reg, final_next;
    logic        len_sel_reg, len_sel_next;
    logic [5:0]  rnd_reg, rnd_next;
    hash_t       chain_reg, chain_next;
    hash_t       bank_reg, bank_next;
    logic [3:0]  left_reg, left_next;

    sched_ctl_t  sctl;
    rnd_ctl_t    rctl;
    word_t       wt;
    hash_t       work;

    sha_sched u_sched (
        .clk (clk),
        .ctl (sctl),
        .wt  (wt)
    );

    sha_round u_round (
        .clk   (clk),
        .ctl   (rctl),
        .chain (chain_reg),
        .wt    (wt),
        .work  (work)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (left_reg != 4'd0);
    assign m_tdata  = bank_reg[0];
    assign m_tuser  = 3'(DIGEST_LEN - left_reg);
    assign m_tlast  = (left_reg == 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        pad_next       = pad_reg;
        pad_first_next = pad_first_reg;
        final_next     = final_reg;
        len_sel_next   = len_sel_reg;
        rnd_next       = rnd_reg;
        chain_next     = chain_reg;
        bank_next      = bank_reg;
        left_next      = left_reg;
        sctl           = '0;
        rctl           = '0;
        rctl.idx       = rnd_reg;

        if (m_tvalid && m_tready)
        begin
            for (int i = 0; i < 7; i++)
            begin
                bank_next[i] = bank_reg[i + 1];
            end
            left_next = left_reg - 4'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        sctl.byte_en   = 1'b1;
                        sctl.byte_val  = s_tdata;
                        sctl.word_done = (cnt_reg[1:0] == 2'd3);
                        cnt_next       = cnt_reg + 6'd1;
                        bits_next      = bits_reg + 64'd8;
                    end
                    if (s_tuser[0] && cnt_reg == LAST_BYTE)
                    begin
                        state_next     = ST_ROUND;
                        rctl.init      = 1'b1;
                        pad_next       = s_tlast;
                        pad_first_next = 1'b1;
                    end
                    else if (s_tlast)
                    begin
                        state_next     = ST_PAD;
                        pad_next       = 1'b1;
                        pad_first_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_first_reg || cnt_reg != LEN_OFFSET)
                begin
                    sctl.byte_en   = 1'b1;
                    sctl.byte_val  = pad_first_reg ? PAD_BYTE : 8'h00;
                    sctl.word_done = (cnt_reg[1:0] == 2'd3);
                    cnt_next       = cnt_reg + 6'd1;
                    pad_first_next = 1'b0;
                    if (cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_ROUND;
                        rctl.init  = 1'b1;
                    end
                end
                else
                begin
                    state_next   = ST_LEN;
                    len_sel_next = 1'b0;
                end
            end
            ST_LEN:
            begin
                sctl.word_en  = 1'b1;
                sctl.word_val = len_sel_reg ? bits_reg[31:0] : bits_reg[63:32];
                len_sel_next  = 1'b1;
                if (len_sel_reg)
                begin
                    state_next = ST_ROUND;
                    rctl.init  = 1'b1;
                    final_next = 1'b1;
                    cnt_next   = '0;
                end
            end
            ST_ROUND:
            begin
                rctl.step = 1'b1;
                sctl.step = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (final_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (left_reg == 4'd0)
                begin
                    bank_next  = chain_reg;
                    left_next  = DIGEST_LEN;
                    chain_next = INIT_HASH;
                    cnt_next   = '0;
                    bits_next  = '0;
                    pad_next   = 1'b0;
                    final_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bits_reg      <= '0;
            pad_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            final_reg     <= 1'b0;
            len_sel_reg   <= 1'b0;
            rnd_reg       <= '0;
            chain_reg     <= INIT_HASH;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bits_reg      <= bits_next;
            pad_reg       <= pad_next;
            pad_first_reg <= pad_first_next;
            final_reg     <= final_next;
            len_sel_reg   <= len_sel_next;
            rnd_reg       <= rnd_next;
            chain_reg     <= chain_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
    end

endmodule
`default_nettype wire

FILE: hdl/sha_sched.sv
`default_nettype none
module sha_sched (
    input  wire                clk,
    input  sha_pkg::sched_ctl_t ctl,
    output sha_pkg::word_t     wt
);
    import sha_pkg::*;

    word_t       win_reg [16];
    word_t       win_next [16];
    logic [23:0] acc_reg;
    logic [23:0] acc_next;
    word_t       expand;
    logic        shift_en;
    word_t       shift_in;

    assign wt     = win_reg[0];
    assign expand = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];

    always_comb
    begin
        acc_next = acc_reg;
        shift_en = 1'b0;
        shift_in = expand;
        if (ctl.byte_en)
        begin
            acc_next = {acc_reg[15:0], ctl.byte_val};
            if (ctl.word_done)
            begin
                shift_en = 1'b1;
                shift_in = {acc_reg, ctl.byte_val};
            end
        end
        else if (ctl.word_en)
        begin
            shift_en = 1'b1;
            shift_in = ctl.word_val;
        end
        else if (ctl.step)
        begin
            shift_en = 1'b1;
        end
        for (int i = 0; i < 15; i++)
        begin
            win_next[i] = shift_en ? win_reg[i + 1] : win_reg[i];
        end
        win_next[15] = shift_en ? shift_in : win_reg[15];
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sha_round.sv
`default_nettype none
module sha_round (
    input  wire               clk,
    input  sha_pkg::rnd_ctl_t ctl,
    input  sha_pkg::hash_t    chain,
    input  sha_pkg::word_t    wt,
    output sha_pkg::hash_t    work
);
    import sha_pkg::*;

    hash_t work_reg;
    hash_t work_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign work = work_reg;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + bsig1(work_reg[4]) + ch + round_k(ctl.idx) + wt;
        t2  = bsig0(work_reg[0]) + maj;
        work_next = work_reg;
        if (ctl.init)
        begin
            work_next = chain;
        end
        else if (ctl.step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule
`default_nettype wire

FILE: hdl/sha_checker.sv
`default_nettype none
module sha_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        s_tlast,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [2:0]  m_tuser,
    input wire        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("last word flag not on word seven");

    a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
        else $error("digest words out of order");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after message end");

endmodule

bind sha256_hash_engine sha_checker u_chk (.*);
`default_nettype wire

FILE: test/tb_sha256_hash_engine.sv
`default_nettype none
module tb_sha256_hash_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED = 16;

    localparam logic [0:7][31:0] H_START = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } digest_exp_t;

    typedef struct packed {
        logic [7:0]   value;
        logic         present;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_value
    logic [0:0]  s_tuser;   // [0] byte_present
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] word_number
    logic        m_tlast;

    logic [31:0] chain_h [8];
    logic [31:0] sched_w [16];
    int unsigned fill_cnt;
    logic [63:0] bit_len;

    digest_exp_t digest_q [$];
    digest_exp_t want;
    dir_row_t    dir_tab [N_DIRECTED];

    int errors;
    int cycles;
    int idle_pct;
    int stall_pct;
    int sent_items;

    sha256_hash_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sha256_hash_engine] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic run_rounds();
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, w15, w2;
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t >= 16)
            begin
                w15 = sched_w[(t - 15) & 15];
                w2  = sched_w[(t - 2) & 15];
                s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
                s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
                sched_w[t & 15] = s1 + sched_w[(t - 7) & 15] + s0 + sched_w[t & 15];
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + sched_w[t & 15];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic load_byte(input logic [7:0] b);
        int unsigned idx;
        idx = fill_cnt >> 2;
        if ((fill_cnt & 3) == 0)
            sched_w[idx] = {b, 24'h0};
        else
            sched_w[idx] = sched_w[idx] | (32'(b) << (8 * (3 - (fill_cnt & 3))));
        fill_cnt++;
        if (fill_cnt == 64)
        begin
            run_rounds();
            fill_cnt = 0;
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            chain_h[i] = H_START[i];
        fill_cnt = 0;
        bit_len = '0;
    endtask

    // update the running hash with one accepted item; queue the digest on message end
    task automatic hash_item(input logic [7:0] value, input logic present, input logic last);
        digest_exp_t e;
        if (present)
        begin
            load_byte(value);
            bit_len = bit_len + 64'd8;
        end
        if (last)
        begin
            load_byte(8'h80);
            while (fill_cnt != 56)
                load_byte(8'h00);
            sched_w[14] = bit_len[63:32];
            sched_w[15] = bit_len[31:0];
            run_rounds();
            for (int k = 0; k < 8; k++)
            begin
                e.word = chain_h[k];
                e.pos = 3'(k);
                e.last = (k == 7);
                digest_q = {digest_q, e};
            end
            restart_hash();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest_word %h word_number %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (m_tdata !== want.word)
                begin
                    $error("digest_word: expected %h, got %h", want.word, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.pos)
                begin
                    $error("word_number: expected %0d, got %0d", want.pos, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_word: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [7:0] value, input logic present, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        hash_item(value, present, last);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (digest_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_message(input int len);
        logic end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int msgs;
        int len;
        int base;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        sent_items = 0;
        msgs = 0;
        restart_hash();
        for (int i = 0; i < 16; i++)
            sched_w[i] = '0;

        dir_tab = '{
            '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
            '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
            '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h7f, 1'b0, 1'b1, 1'b0, 256'h0},
            '{8'h5a, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'hc3, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0}
        };

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_item(dir_tab[r].value, dir_tab[r].present, dir_tab[r].last);
            if (dir_tab[r].last && dir_tab[r].known)
            begin
                base = digest_q.size() - 8;
                for (int k = 0; k < 8; k++)
                    digest_q[base + k].word = dir_tab[r].digest[255 - 32 * k -: 32];
            end
        end

        drain_digests();

        while (sent_items < 160 || msgs < 4)
        begin
            case (msgs % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            // two-block padding and exact block fill first
            if (msgs == 0)
                len = 56;
            else if (msgs == 1)
                len = 64;
            else
                len = $urandom_range(12);
            send_message(len);
            msgs++;
            if ($urandom_range(7) == 0)
                drain_digests();
        end

        drain_digests();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[sha256_hash_engine] OK");
        else
            $display("[sha256_hash_engine] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
